// ===== src/gwd_pkg.sv =====
// Shared types, constants and helper functions for the genotype word decoder.
package gwd_pkg;

	localparam int WORD_BITS  = 64;
	localparam int COUNT_BITS = 22;
	localparam int INC_BITS   = $clog2(WORD_BITS + 1);
	localparam int SAMP_BITS  = 20;
	localparam int FREQ_BITS  = 16;
	localparam int DIV_CNT_BITS = $clog2(FREQ_BITS);

	localparam logic [WORD_BITS-1:0] WORD_MASK = {WORD_BITS{1'b1}};
	localparam logic [WORD_BITS-1:0] PAIR_LOW_MASK = {(WORD_BITS / 2){2'b01}};
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Configuration register indexes
	localparam logic REG_LD_MODE      = 1'b0;
	localparam logic REG_SAMPLE_COUNT = 1'b1;

	// Output bus layout
	localparam int TDATA_BITS = 2 * WORD_BITS + FREQ_BITS;
	localparam int TUSER_BITS = 2;

	// One classified word, passed from the front end to the back end.
	typedef struct packed {
		logic [WORD_BITS-1:0] geno;
		logic [WORD_BITS-1:0] present;
		logic [INC_BITS-1:0]  allele_inc;
		logic [INC_BITS-1:0]  miss_inc;
		logic                 last;
	} gwd_entry_t;

	function automatic logic [INC_BITS-1:0] popcount(input logic [WORD_BITS-1:0] v);
		logic [INC_BITS-1:0] n;
		n = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			n = n + INC_BITS'(v[i]);
		end
		return n;
	endfunction

	function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] acc,
			input logic [INC_BITS-1:0] inc);
		logic [COUNT_BITS:0] s;
		s = {1'b0, acc} + (COUNT_BITS + 1)'(inc);
		return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
	endfunction

endpackage

// ===== src/gwd_front.sv =====
// Front end: find missing pairs, build present mask, recode word, count bits.
module gwd_front (
	input  logic [gwd_pkg::WORD_BITS-1:0] raw_word,
	input  logic                          last_word,
	input  logic                          ld_mode,
	output gwd_pkg::gwd_entry_t           entry
);
	import gwd_pkg::*;

	logic [WORD_BITS-1:0] word;
	logic [WORD_BITS-1:0] low;
	logic [WORD_BITS-1:0] lone;
	logic [WORD_BITS-1:0] miss;
	logic [WORD_BITS-1:0] present;

	always_comb begin
		word    = raw_word & WORD_MASK;
		low     = word & PAIR_LOW_MASK;
		// code 01: low bit set, high bit clear
		lone    = low & ~(word >> 1);
		miss    = (lone | (lone << 1)) & WORD_MASK;
		present = ~miss & WORD_MASK;

		entry.geno       = ld_mode ? ((word ^ (low >> 1)) & present) : word;
		entry.present    = present;
		entry.allele_inc = popcount(word & present);
		entry.miss_inc   = popcount(miss);
		entry.last       = last_word;
	end

endmodule

// ===== src/gwd_queue.sv =====
// Two-entry queue between the front end and the back end.
module gwd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gwd_pkg::gwd_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output gwd_pkg::gwd_entry_t head_entry
);
	import gwd_pkg::*;

	gwd_entry_t  mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/gwd_back.sv =====
// Back end: accumulate counts, divide for the frequency, drive the output register.
module gwd_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [gwd_pkg::SAMP_BITS-1:0]        sample_count,
	input  logic                                 head_valid,
	input  gwd_pkg::gwd_entry_t                  head_entry,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [gwd_pkg::TDATA_BITS-1:0]       out_data,
	output logic [gwd_pkg::TUSER_BITS-1:0]       out_user,
	output logic                                 out_last
);
	import gwd_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_FOLD = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]              state_q;
	logic [COUNT_BITS-1:0]   allele_q;
	logic [COUNT_BITS-1:0]   missing_q;
	logic [WORD_BITS-1:0]    hold_geno_q;
	logic [WORD_BITS-1:0]    hold_present_q;
	logic [COUNT_BITS-1:0]   div_q;
	logic [COUNT_BITS-1:0]   rem_q;
	logic [FREQ_BITS-1:0]    quo_q;
	logic [DIV_CNT_BITS-1:0] step_q;
	logic                    none_q;

	logic                    out_valid_q;
	logic [WORD_BITS-1:0]    out_geno_q;
	logic [WORD_BITS-1:0]    out_present_q;
	logic [FREQ_BITS-1:0]    out_freq_q;
	logic                    out_fvalid_q;
	logic                    out_none_q;
	logic                    out_last_q;

	logic                    out_free;
	logic                    out_load;
	logic [COUNT_BITS-1:0]   total;
	logic [COUNT_BITS-1:0]   clamp_a;
	logic [COUNT_BITS:0]     rem_dbl;
	logic                    rem_ge;

	assign out_free = !out_valid_q || out_ready;
	assign pop      = (state_q == ST_IDLE) && head_valid && (head_entry.last || out_free);
	// output register takes a new transfer this cycle
	assign out_load = (pop && !head_entry.last) || ((state_q == ST_EMIT) && out_free);

	assign total   = {1'b0, sample_count, 1'b0};
	assign clamp_a = (allele_q > div_q) ? div_q : allele_q;
	assign rem_dbl = {rem_q, 1'b0};
	assign rem_ge  = (rem_dbl >= {1'b0, div_q});

	assign out_valid = out_valid_q;
	assign out_data  = {out_freq_q, out_present_q, out_geno_q};
	assign out_user  = {out_none_q, out_fvalid_q};
	assign out_last  = out_last_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (pop) begin
					hold_geno_q    <= head_entry.geno;
					hold_present_q <= head_entry.present;
				end
				if (pop && !head_entry.last) begin
					out_geno_q    <= head_entry.geno;
					out_present_q <= head_entry.present;
					out_freq_q    <= '0;
					out_fvalid_q  <= 1'b0;
					out_none_q    <= 1'b0;
					out_last_q    <= 1'b0;
				end
			end
			ST_PREP: begin
				div_q  <= total - missing_q;
				none_q <= (missing_q >= total);
				quo_q  <= '0;
			end
			ST_FOLD: begin
				rem_q  <= ({clamp_a, 1'b0} > {1'b0, div_q}) ? (div_q - clamp_a) : clamp_a;
				step_q <= '0;
			end
			ST_DIV: begin
				rem_q  <= rem_ge ? COUNT_BITS'(rem_dbl - {1'b0, div_q}) : rem_dbl[COUNT_BITS-1:0];
				quo_q  <= {quo_q[FREQ_BITS-2:0], rem_ge};
				step_q <= step_q + 1'b1;
			end
			ST_EMIT: begin
				if (out_free) begin
					out_geno_q    <= hold_geno_q;
					out_present_q <= hold_present_q;
					out_freq_q    <= quo_q;
					out_fvalid_q  <= 1'b1;
					out_none_q    <= none_q;
					out_last_q    <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			allele_q    <= '0;
			missing_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						allele_q  <= sat_add(allele_q, head_entry.allele_inc);
						missing_q <= sat_add(missing_q, head_entry.miss_inc);
						if (head_entry.last) begin
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					state_q <= (missing_q >= total) ? ST_EMIT : ST_FOLD;
				end
				ST_FOLD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == DIV_CNT_BITS'(FREQ_BITS - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						allele_q    <= '0;
						missing_q   <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/packed_genotype_word_decoder.sv =====
// A non-final word goes from the queue into the output register; a final word is popped, then
// runs the prep and fold setup states, a 16-bit restoring division and the emit state; when no
// bit is present it goes from prep straight to emit. A low m_axis_tready can stall either path.
// The back end takes one non-final word per cycle while the output register is free; a final
// word holds it until emit. The two-entry queue lets the front keep accepting meanwhile.
// Reset (arst_n low, asynchronous): queue and output empty, counts zero, ld_mode = 1, sample_count = 1.
module packed_genotype_word_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic                           cfg_idx,
	input  logic [gwd_pkg::SAMP_BITS-1:0]  cfg_wdata,
	// input stream
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [gwd_pkg::WORD_BITS-1:0]  s_axis_tdata,  // raw_word
	input  logic                           s_axis_tlast,  // last_word
	// output stream
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// genotype_word, present_mask, minor_frequency
	output logic [gwd_pkg::TDATA_BITS-1:0] m_axis_tdata,
	output logic [gwd_pkg::TUSER_BITS-1:0] m_axis_tuser,  // frequency_valid, all_missing
	output logic                           m_axis_tlast   // end_of_variant
);
	import gwd_pkg::*;

	logic                 ld_mode_q;
	logic [SAMP_BITS-1:0] sample_count_q;

	gwd_entry_t           front_entry;
	gwd_entry_t           head_entry;
	logic                 q_full;
	logic                 q_head_valid;
	logic                 q_pop;
	logic                 q_push;

	// Configuration registers; the user writes them only while the block is idle, not enforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_mode_q      <= 1'b1;
			sample_count_q <= SAMP_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_LD_MODE:      ld_mode_q      <= cfg_wdata[0];
				REG_SAMPLE_COUNT: sample_count_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Accept a transfer whenever the queue has room; classification is combinational.
	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && s_axis_tready;

	gwd_front u_front (
		.raw_word  (s_axis_tdata),
		.last_word (s_axis_tlast),
		.ld_mode   (ld_mode_q),
		.entry     (front_entry)
	);

	// Hold classified words so the front keeps accepting while the divider runs.
	gwd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (front_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_entry (head_entry)
	);

	// Advance counts, run the frequency division on the last word, drive the output.
	gwd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_count (sample_count_q),
		.head_valid   (q_head_valid),
		.head_entry   (head_entry),
		.pop          (q_pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_data     (m_axis_tdata),
		.out_user     (m_axis_tuser),
		.out_last     (m_axis_tlast)
	);

endmodule

// ===== src/gwd_checker.sv =====
// Port-level checker for the genotype word decoder, bound to the top level.
module gwd_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  cfg_we,
	input logic                                  s_axis_tvalid,
	input logic                                  m_axis_tvalid,
	input logic                                  m_axis_tready,
	input logic [gwd_pkg::TDATA_BITS-1:0]        m_axis_tdata,
	input logic [gwd_pkg::TUSER_BITS-1:0]        m_axis_tuser,
	input logic                                  m_axis_tlast
);
	import gwd_pkg::*;

	logic [WORD_BITS-1:0] present;
	logic [FREQ_BITS-1:0] freq;

	assign present = m_axis_tdata[2*WORD_BITS-1:WORD_BITS];
	assign freq    = m_axis_tdata[TDATA_BITS-1:2*WORD_BITS];

	// A stalled result holds its payload.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output changed while stalled");

	// Frequency fields are only set on the end-of-variant word.
	a_freq_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[0] == m_axis_tlast)
			&& (m_axis_tuser[0] || (freq == '0 && !m_axis_tuser[1])))
		else $error("frequency fields outside the last word");

	// Folded frequency never exceeds one half; all-missing forces zero.
	a_freq_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (freq <= FREQ_BITS'(32768)) && (!m_axis_tuser[1] || freq == '0))
		else $error("frequency out of range");

	// Both bits of a genotype pair share the present bit.
	a_pair_mask: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((present ^ (present >> 1)) & PAIR_LOW_MASK) == '0)
		else $error("present mask splits a pair");

	// Register writes land only while both streams are quiet.
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !s_axis_tvalid && !m_axis_tvalid)
		else $error("register write while a transfer is pending");

endmodule

bind packed_genotype_word_decoder gwd_checker u_gwd_checker (.*);
